### src/assert_macros.svh
// assertion helpers; the asserting module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/pid_dab_pkg.sv
`default_nettype none

package pid_dab_pkg;

    // value and gain formats
    localparam int VALUE_WIDTH    = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int ZONE_W         = 16;
    localparam int LOAD_W         = 15;
    localparam int INTEG_W        = 15;
    localparam int OUT_W          = 32;
    localparam int ERR_W          = VALUE_WIDTH + 1;
    localparam int PROD_W         = GAIN_W + ERR_W;
    localparam int DPROD_W        = GAIN_W + ERR_W + 1;
    localparam int SUM_W          = DPROD_W + 2;
    localparam int FULL_SCALE     = 100 * (2 ** GAIN_FRAC_BITS);

    // action codes
    localparam logic [1:0] ACT_COMPUTE  = 2'd0;
    localparam logic [1:0] ACT_LOAD     = 2'd1;
    localparam logic [1:0] ACT_BUMPLESS = 2'd2;

    // config register indexes
    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [1:0] REG_DEAD_ZONE  = 2'd3;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [VALUE_WIDTH-1:0] process_value;
        logic signed [VALUE_WIDTH-1:0] target_value;
        logic [LOAD_W-1:0]            load_value;
    } pid_dab_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] control_out;
        logic                    in_dead_zone;
    } pid_dab_out_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [ZONE_W-1:0]        dead_zone;
    } pid_dab_cfg_t;

    typedef struct packed {
        logic [INTEG_W-1:0]      integ;
        logic signed [ERR_W-1:0] prev_err;
    } pid_dab_state_t;

endpackage

`default_nettype wire

### src/pid_dab_core.sv
`default_nettype none

module pid_dab_core
    import pid_dab_pkg::*;
(
    input  wire pid_dab_cfg_t   cfg,
    input  wire pid_dab_state_t state,
    input  wire pid_dab_in_t    item,
    output pid_dab_state_t      state_next,
    output pid_dab_out_t        result
);

    localparam logic signed [PROD_W-1:0]  FS_P    = PROD_W'(FULL_SCALE);
    localparam logic signed [PROD_W:0]    FS_I    = (PROD_W + 1)'(FULL_SCALE);
    localparam logic [INTEG_W-1:0]        FS_INT  = INTEG_W'(FULL_SCALE);
    localparam logic signed [SUM_W-1:0]   OUT_MAX = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0]   OUT_MIN = -OUT_MAX - SUM_W'(1);

    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          err_mag;
    logic                      dz_hit;
    logic signed [PROD_W-1:0]  pterm;
    logic signed [PROD_W-1:0]  iterm;
    logic                      p_big;
    logic signed [PROD_W:0]    isum;
    logic [INTEG_W-1:0]        isum_clamp;
    logic [INTEG_W-1:0]        integ_upd;
    logic signed [ERR_W:0]     diff;
    logic signed [DPROD_W-1:0] dterm;
    logic signed [SUM_W-1:0]   total;
    logic signed [OUT_W-1:0]   total_sat;
    logic [INTEG_W-1:0]        load_clamp;

    // error and its magnitude against the dead zone
    assign err     = ERR_W'(item.target_value) - ERR_W'(item.process_value);
    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign dz_hit  = (err_mag <= cfg.dead_zone);

    // proportional term and anti-windup test
    assign pterm = PROD_W'(cfg.prop_gain) * PROD_W'(err);
    assign p_big = (pterm > FS_P) || (pterm < -FS_P);

    // integral accumulate with clamp to 0..full scale
    assign iterm = PROD_W'(cfg.integ_gain) * PROD_W'(err);
    assign isum  = (PROD_W + 1)'(iterm) + (PROD_W + 1)'($signed({1'b0, state.integ}));

    always_comb
    begin
        if (isum > FS_I)
        begin
            isum_clamp = FS_INT;
        end
        else if (isum[PROD_W])
        begin
            isum_clamp = '0;
        end
        else
        begin
            isum_clamp = isum[INTEG_W-1:0];
        end
    end

    assign integ_upd = p_big ? '0 : isum_clamp;

    // derivative term
    assign diff  = (ERR_W + 1)'(err) - (ERR_W + 1)'(state.prev_err);
    assign dterm = DPROD_W'(diff) * DPROD_W'(cfg.deriv_gain);

    // output sum and saturation
    assign total = SUM_W'(pterm) + SUM_W'($signed({1'b0, integ_upd})) + SUM_W'(dterm);

    always_comb
    begin
        if (total > OUT_MAX)
        begin
            total_sat = OUT_MAX[OUT_W-1:0];
        end
        else if (total < OUT_MIN)
        begin
            total_sat = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            total_sat = total[OUT_W-1:0];
        end
    end

    assign load_clamp = (item.load_value > FS_INT) ? FS_INT : item.load_value;

    // action select
    always_comb
    begin
        state_next          = state;
        result.control_out  = OUT_W'($signed({1'b0, state.integ}));
        result.in_dead_zone = 1'b0;
        case (item.action)
            ACT_COMPUTE:
            begin
                state_next.prev_err = err;
                if (dz_hit)
                begin
                    result.in_dead_zone = 1'b1;
                end
                else
                begin
                    state_next.integ   = integ_upd;
                    result.control_out = total_sat;
                end
            end
            ACT_LOAD:
            begin
                state_next.integ    = load_clamp;
                state_next.prev_err = '0;
                result.control_out  = OUT_W'($signed({1'b0, load_clamp}));
            end
            ACT_BUMPLESS:
            begin
                state_next.prev_err = err;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/pid_dab_top_regs.sv
`default_nettype none

module pid_dab_top_regs
    import pid_dab_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [ZONE_W-1:0] cfg_data,
    output pid_dab_cfg_t     cfg
);

    pid_dab_cfg_t cfg_reg;
    pid_dab_cfg_t cfg_next;

    // decode a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PROP_GAIN:  cfg_next.prop_gain  = $signed(cfg_data[GAIN_W-1:0]);
                REG_INTEG_GAIN: cfg_next.integ_gain = $signed(cfg_data[GAIN_W-1:0]);
                REG_DERIV_GAIN: cfg_next.deriv_gain = $signed(cfg_data[GAIN_W-1:0]);
                REG_DEAD_ZONE:  cfg_next.dead_zone  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/pid_deadband_antiwindup.sv
// positional pid step with dead zone and integral anti-windup, fixed point
// input channel in_valid/in_ready/in_data carries one beat per control sample:
//   action 0 computes a step, 1 loads the integral, 2 re-bases the last error
// output channel out_valid/out_ready/out_data returns exactly one beat per input
//   beat, in order: control_out in units of 1/256 and the in_dead_zone flag
// gains and dead zone are written on cfg_wr_en/cfg_index/cfg_data while idle
// a beat in the input register moves into the result register and out_data
//   when that register is free; throughput: one beat per cycle while out_ready
//   is high; the whole step is one pass through two 16x17 multipliers, one
//   16x18 multiplier and the sum/clamp logic between the input register and
//   the result register, with the integral and last error updated in that pass
// reset clears gains, dead zone, integral, last error and both valid flags
// when the receiver stalls the result register holds; the input register takes
//   one more beat if empty, then in_ready drops until out_ready returns
`default_nettype none

module pid_deadband_antiwindup
    import pid_dab_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [ZONE_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pid_dab_in_t       in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pid_dab_out_t           out_data
);

`include "assert_macros.svh"

    pid_dab_cfg_t   cfg;
    pid_dab_state_t state_reg;
    pid_dab_state_t state_next;
    pid_dab_in_t    item_reg;
    logic           item_vld_reg;
    pid_dab_out_t   res_reg;
    pid_dab_out_t   res_next;
    logic           res_vld_reg;
    logic           advance;

    // configuration registers
    pid_dab_top_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // step datapath
    pid_dab_core u_core (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // handshake: item moves into the result register when that is free
    assign advance  = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    // controller state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

    // checks
    `ASSERT_ALWAYS(a_integ_range,
                   state_reg.integ <= INTEG_W'(FULL_SCALE),
                   "integral above full scale")
    `ASSERT_IMPLY(a_dz_holds_integ,
                  res_vld_reg && res_reg.in_dead_zone,
                  res_reg.control_out == OUT_W'($signed({1'b0, state_reg.integ})),
                  "dead zone result differs from integral")
    `ASSERT_NEXT(a_advance_fills, advance, res_vld_reg, "result lost after advance")

endmodule

`default_nettype wire
